// ----- sv/cau_pkg.sv -----
// shared constants, codes and types of the complex arithmetic unit
package cau_pkg;

   localparam int WIDTH       = 32;
   localparam int FRAC_BITS   = 24;
   localparam int ACT_W       = 3;
   localparam int PROD_W      = 2 * WIDTH;
   localparam int NUM_W       = PROD_W + FRAC_BITS;
   localparam int CMP_W       = (NUM_W > 3 * WIDTH) ? NUM_W : 3 * WIDTH;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [ACT_W-1:0] ACT_ADD  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_SUB  = 3'd1;
   localparam logic [ACT_W-1:0] ACT_MUL  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_DIV  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CONJ = 3'd4;
   localparam logic [ACT_W-1:0] ACT_MAG  = 3'd5;

   localparam logic [WIDTH-1:0] SAT_MAX = {1'b0, {(WIDTH - 1){1'b1}}};
   localparam logic [WIDTH-1:0] SAT_MIN = {1'b1, {(WIDTH - 1){1'b0}}};

   typedef enum logic [6:0] {
      OP_NONE = 7'b0000001,
      OP_ADD  = 7'b0000010,
      OP_SUB  = 7'b0000100,
      OP_MUL  = 7'b0001000,
      OP_DIV  = 7'b0010000,
      OP_CONJ = 7'b0100000,
      OP_MAG  = 7'b1000000
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic signed [WIDTH-1:0]  a_re;
      logic signed [WIDTH-1:0]  a_im;
      logic signed [WIDTH-1:0]  b_re;
      logic signed [WIDTH-1:0]  b_im;
   } entry_type;

endpackage

// ----- sv/cau_if.sv -----
// request and response channel interfaces of the complex arithmetic unit
interface cau_req_if
   import cau_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic [ACT_W-1:0]         action;
   logic signed [WIDTH-1:0]  a_re;
   logic signed [WIDTH-1:0]  a_im;
   logic signed [WIDTH-1:0]  b_re;
   logic signed [WIDTH-1:0]  b_im;

   modport source (output valid, action, a_re, a_im, b_re, b_im, input ready);
   modport sink (input valid, action, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if
   import cau_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [WIDTH-1:0]  res_re;
   logic signed [WIDTH-1:0]  res_im;
   logic                     overflow;
   logic                     div_zero;

   modport source (output valid, res_re, res_im, overflow, div_zero, input ready);
   modport sink (input valid, res_re, res_im, overflow, div_zero, output ready);
endinterface

// ----- sv/cau_front.sv -----
// request intake: action decode and a short queue towards the arithmetic pipe
module cau_front
   import cau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   output logic       q_valid,
   output entry_type  q_entry,
   input  logic       q_pop
);

   entry_type           queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   entry_type           new_entry;
   logic                push;

   always_comb begin
      new_entry.a_re = req_if.a_re;
      new_entry.a_im = req_if.a_im;
      new_entry.b_re = req_if.b_re;
      new_entry.b_im = req_if.b_im;
      unique case (req_if.action)
         ACT_ADD:  new_entry.op = OP_ADD;
         ACT_SUB:  new_entry.op = OP_SUB;
         ACT_MUL:  new_entry.op = OP_MUL;
         ACT_DIV:  new_entry.op = OP_DIV;
         ACT_CONJ: new_entry.op = OP_CONJ;
         ACT_MAG:  new_entry.op = OP_MAG;
         default:  new_entry.op = OP_NONE;
      endcase
   end

   assign req_if.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_if.valid && req_if.ready;
   assign q_valid      = (count_ff != '0);
   assign q_entry      = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// ----- sv/cau_back.sv -----
// arithmetic pipe: products, combine, range check, restoring divider, saturation
module cau_back
   import cau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   cau_rsp_if.source  rsp_if
);

   typedef struct packed {
      logic               neg_re;
      logic               neg_im;
      logic               big_re;
      logic               big_im;
      logic               dz;
      logic [NUM_W-1:0]   x_re;
      logic [NUM_W-1:0]   x_im;
      logic [PROD_W-1:0]  d;
      logic [WIDTH-1:0]   q_re;
      logic [WIDTH-1:0]   q_im;
   } div_type;

   function automatic logic [NUM_W-1:0] scale_mag(input logic signed [PROD_W:0] v,
                                                  input logic up, input logic down);
      logic [PROD_W:0]    neg_v;
      logic [PROD_W-1:0]  mag;
      logic [NUM_W-1:0]   r;
      neg_v = -v;
      mag   = v[PROD_W] ? neg_v[PROD_W-1:0] : v[PROD_W-1:0];
      if (up) begin
         r = NUM_W'(mag) << FRAC_BITS;
      end else if (down) begin
         r = NUM_W'(mag >> FRAC_BITS);
      end else begin
         r = NUM_W'(mag);
      end
      return r;
   endfunction

   function automatic logic [WIDTH:0] saturate(input logic neg, input logic big,
                                               input logic [WIDTH-1:0] q);
      logic [WIDTH:0] r;
      if (neg) begin
         if (big || q > SAT_MIN) r = {1'b1, SAT_MIN};
         else                    r = {1'b0, -q};
      end else begin
         if (big || q > SAT_MAX) r = {1'b1, SAT_MAX};
         else                    r = {1'b0, q};
      end
      return r;
   endfunction

   logic advance;

   // multiply stage
   logic                      s1_valid_ff;
   op_type                    op1_ff;
   logic signed [PROD_W-1:0]  m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [PROD_W-1:0]  m0_in, m1_in, m2_in, m3_in, m4_in, m5_in;
   logic signed [WIDTH:0]     s_re_ff, s_im_ff, s_re_in, s_im_in;
   logic signed [WIDTH-1:0]   sq_x, sq_y;

   // combine stage
   logic                      s2_valid_ff;
   logic [NUM_W-1:0]          c_x_re_ff, c_x_im_ff, c_x_re_in, c_x_im_in;
   logic                      c_neg_re_ff, c_neg_im_ff, c_dz_ff;
   logic                      c_dz_in;
   logic [PROD_W-1:0]         c_d_ff, c_d_in;
   logic signed [PROD_W:0]    v_re, v_im;
   logic [PROD_W-1:0]         den;
   logic                      up, down;

   // range check and divider stages
   logic                      pv_ff [0:WIDTH];
   div_type                   pipe_ff [0:WIDTH];
   div_type                   stage0_in;
   div_type                   stage_in [1:WIDTH];

   // output register
   logic                      out_valid_ff;
   logic [WIDTH-1:0]          res_re_ff, res_im_ff;
   logic                      ovf_ff, dz_ff;
   logic [WIDTH:0]            sat_re, sat_im;

   assign advance = !out_valid_ff || rsp_if.ready;
   assign q_pop   = advance && q_valid;

   always_comb begin
      sq_x  = (q_entry.op == OP_MAG) ? q_entry.a_re : q_entry.b_re;
      sq_y  = (q_entry.op == OP_MAG) ? q_entry.a_im : q_entry.b_im;
      m0_in = PROD_W'(q_entry.a_re) * PROD_W'(q_entry.b_re);
      m1_in = PROD_W'(q_entry.a_im) * PROD_W'(q_entry.b_im);
      m2_in = PROD_W'(q_entry.a_re) * PROD_W'(q_entry.b_im);
      m3_in = PROD_W'(q_entry.a_im) * PROD_W'(q_entry.b_re);
      m4_in = PROD_W'(sq_x) * PROD_W'(sq_x);
      m5_in = PROD_W'(sq_y) * PROD_W'(sq_y);
      s_re_in = '0;
      s_im_in = '0;
      unique case (q_entry.op)
         OP_ADD: begin
            s_re_in = (WIDTH + 1)'(q_entry.a_re) + (WIDTH + 1)'(q_entry.b_re);
            s_im_in = (WIDTH + 1)'(q_entry.a_im) + (WIDTH + 1)'(q_entry.b_im);
         end
         OP_SUB: begin
            s_re_in = (WIDTH + 1)'(q_entry.a_re) - (WIDTH + 1)'(q_entry.b_re);
            s_im_in = (WIDTH + 1)'(q_entry.a_im) - (WIDTH + 1)'(q_entry.b_im);
         end
         OP_CONJ: begin
            s_re_in = (WIDTH + 1)'(q_entry.a_re);
            s_im_in = -((WIDTH + 1)'(q_entry.a_im));
         end
         default: begin
            s_re_in = '0;
            s_im_in = '0;
         end
      endcase
   end

   always_comb begin
      v_re = '0;
      v_im = '0;
      up   = 1'b0;
      down = 1'b0;
      den  = PROD_W'(m4_ff) + PROD_W'(m5_ff);
      unique case (op1_ff) inside
         OP_ADD, OP_SUB, OP_CONJ: begin
            v_re = (PROD_W + 1)'(s_re_ff);
            v_im = (PROD_W + 1)'(s_im_ff);
         end
         OP_MUL: begin
            v_re = (PROD_W + 1)'(m0_ff) - (PROD_W + 1)'(m1_ff);
            v_im = (PROD_W + 1)'(m2_ff) + (PROD_W + 1)'(m3_ff);
            down = 1'b1;
         end
         OP_DIV: begin
            v_re = (PROD_W + 1)'(m0_ff) + (PROD_W + 1)'(m1_ff);
            v_im = (PROD_W + 1)'(m3_ff) - (PROD_W + 1)'(m2_ff);
            up   = 1'b1;
         end
         OP_MAG: begin
            v_re = (PROD_W + 1)'(m4_ff) + (PROD_W + 1)'(m5_ff);
            down = 1'b1;
         end
         default: begin
            v_re = '0;
            v_im = '0;
         end
      endcase
      c_dz_in   = (op1_ff == OP_DIV) && (den == '0);
      c_x_re_in = c_dz_in ? '0 : scale_mag(v_re, up, down);
      c_x_im_in = c_dz_in ? '0 : scale_mag(v_im, up, down);
      c_d_in    = ((op1_ff == OP_DIV) && !c_dz_in) ? den : PROD_W'(1);
   end

   // quotient of 2^WIDTH or more can only saturate
   always_comb begin
      stage0_in.neg_re = c_neg_re_ff;
      stage0_in.neg_im = c_neg_im_ff;
      stage0_in.dz     = c_dz_ff;
      stage0_in.x_re   = c_x_re_ff;
      stage0_in.x_im   = c_x_im_ff;
      stage0_in.d      = c_d_ff;
      stage0_in.q_re   = '0;
      stage0_in.q_im   = '0;
      stage0_in.big_re = CMP_W'(c_x_re_ff) >= (CMP_W'(c_d_ff) << WIDTH);
      stage0_in.big_im = CMP_W'(c_x_im_ff) >= (CMP_W'(c_d_ff) << WIDTH);
   end

   for (genvar k = 0; k < WIDTH; k++) begin : g_div
      localparam int SH = WIDTH - 1 - k;
      logic [CMP_W-1:0]  dsh, rem_re, rem_im;
      logic              ge_re, ge_im;

      always_comb begin
         dsh    = CMP_W'(pipe_ff[k].d) << SH;
         ge_re  = CMP_W'(pipe_ff[k].x_re) >= dsh;
         ge_im  = CMP_W'(pipe_ff[k].x_im) >= dsh;
         rem_re = CMP_W'(pipe_ff[k].x_re) - dsh;
         rem_im = CMP_W'(pipe_ff[k].x_im) - dsh;
         stage_in[k + 1] = pipe_ff[k];
         if (ge_re) begin
            stage_in[k + 1].x_re     = rem_re[NUM_W-1:0];
            stage_in[k + 1].q_re[SH] = 1'b1;
         end
         if (ge_im) begin
            stage_in[k + 1].x_im     = rem_im[NUM_W-1:0];
            stage_in[k + 1].q_im[SH] = 1'b1;
         end
      end
   end

   assign sat_re = saturate(pipe_ff[WIDTH].neg_re, pipe_ff[WIDTH].big_re, pipe_ff[WIDTH].q_re);
   assign sat_im = saturate(pipe_ff[WIDTH].neg_im, pipe_ff[WIDTH].big_im, pipe_ff[WIDTH].q_im);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i <= WIDTH; i++) begin
            pv_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         s2_valid_ff  <= s1_valid_ff;
         pv_ff[0]     <= s2_valid_ff;
         for (int i = 1; i <= WIDTH; i++) begin
            pv_ff[i] <= pv_ff[i - 1];
         end
         out_valid_ff <= pv_ff[WIDTH];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         op1_ff      <= q_entry.op;
         m0_ff       <= m0_in;
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
         m3_ff       <= m3_in;
         m4_ff       <= m4_in;
         m5_ff       <= m5_in;
         s_re_ff     <= s_re_in;
         s_im_ff     <= s_im_in;
         c_x_re_ff   <= c_x_re_in;
         c_x_im_ff   <= c_x_im_in;
         c_neg_re_ff <= v_re[PROD_W];
         c_neg_im_ff <= v_im[PROD_W];
         c_dz_ff     <= c_dz_in;
         c_d_ff      <= c_d_in;
         pipe_ff[0]  <= stage0_in;
         for (int i = 1; i <= WIDTH; i++) begin
            pipe_ff[i] <= stage_in[i];
         end
         res_re_ff   <= sat_re[WIDTH-1:0];
         res_im_ff   <= sat_im[WIDTH-1:0];
         ovf_ff      <= sat_re[WIDTH] || sat_im[WIDTH];
         dz_ff       <= pipe_ff[WIDTH].dz;
      end
   end

   assign rsp_if.valid    = out_valid_ff;
   assign rsp_if.res_re   = res_re_ff;
   assign rsp_if.res_im   = res_im_ff;
   assign rsp_if.overflow = ovf_ff;
   assign rsp_if.div_zero = dz_ff;

endmodule

// ----- sv/complex_arithmetic_unit.sv -----
// top level of the complex arithmetic unit
// Stateless complex add, subtract, multiply, divide, conjugate and squared magnitude on
// 32-bit signed fixed point with 24 fraction bits. One item is taken every cycle while the
// response side does not stall, and results come back in order; the depth is set by the
// restoring divider, one quotient bit per stage, which every action passes through so that
// all results keep the same latency. A two-entry queue sits between the intake and the
// arithmetic pipe, and the response is held in an output register, so requests are still
// taken while a finished result waits to be taken, until the queue is full.
module complex_arithmetic_unit
   import cau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   cau_req_if.sink    req_if,
   cau_rsp_if.source  rsp_if
);

   logic       q_valid;
   logic       q_pop;
   entry_type  q_entry;

   cau_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop)
   );

   cau_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_pop   (q_pop),
      .rsp_if  (rsp_if)
   );

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.div_zero |->
         rsp_if.res_re == '0 && rsp_if.res_im == '0 && !rsp_if.overflow)
      else $error("divide by zero result not cleared");

   a_ovf_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.overflow |->
         rsp_if.res_re == SAT_MAX || rsp_if.res_re == SAT_MIN ||
         rsp_if.res_im == SAT_MAX || rsp_if.res_im == SAT_MIN)
      else $error("overflow flagged without a saturated part");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid straight after reset");

   a_no_early_pop: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !q_pop)
      else $error("queue read straight after reset");

endmodule
